// ----- rtl/lbat_pkg.sv -----
// Package with the item types, field widths and command codes of the LRU budget tracker.
`timescale 1ns / 1ps
package lbat_pkg;

  localparam int SIZE_W = 48;
  localparam int USED_W = 54;
  localparam int HALF_W = 32;
  localparam int KEY_W  = 2 * HALF_W;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_TOUCH = 2'd2;
  localparam logic [1:0] MODE_EVICT = 2'd3;

  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_OVER = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;
  localparam logic [1:0] STAT_MISS = 2'd3;

  typedef struct packed {
    logic [1:0]        mode;
    logic [HALF_W-1:0] handle_index;
    logic [HALF_W-1:0] handle_generation;
    logic [SIZE_W-1:0] size_bytes;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              evicted_valid;
    logic [HALF_W-1:0] evicted_index;
    logic [HALF_W-1:0] evicted_generation;
    logic [USED_W-1:0] used_bytes;
  } out_item_t;

  // Classified request handed from the front queue to the back end.
  typedef struct packed {
    logic [1:0]        mode;
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
    logic              over;
  } cmd_t;

endpackage

// ----- rtl/lbat_front.sv -----
// Front end: accepts requests, masks the size, checks the budget and queues them.
`timescale 1ns / 1ps
module lbat_front #(
  parameter int SIZE_BITS = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lbat_pkg::in_item_t            in_data,
  input  logic [lbat_pkg::SIZE_W-1:0]   budget,
  output logic                          q_valid,
  output lbat_pkg::cmd_t                q_cmd,
  input  logic                          q_pop
);
  import lbat_pkg::*;

  localparam logic [SIZE_W-1:0] SZ_MASK = (SIZE_BITS >= SIZE_W) ? {SIZE_W{1'b1}} :
                                          SIZE_W'((65'd1 << SIZE_BITS) - 65'd1);

  cmd_t       q_mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       push;
  logic       pop;
  cmd_t       new_cmd;
  logic [SIZE_W-1:0] msize;

  assign msize        = in_data.size_bytes & SZ_MASK;
  assign new_cmd.mode = in_data.mode;
  assign new_cmd.key  = {in_data.handle_generation, in_data.handle_index};
  assign new_cmd.size = msize;
  assign new_cmd.over = (msize > budget);

  assign in_stall = (cnt_r == 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_mem_r[rp_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_valid && q_pop;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (!push && pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wp_r] <= new_cmd;
  end

endmodule

// ----- rtl/lbat_back.sv -----
// Back end: scans the entry table, applies the request and sweeps the recency ranks.
`timescale 1ns / 1ps
module lbat_back #(
  parameter int ENTRIES = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  lbat_pkg::cmd_t       q_cmd,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lbat_pkg::out_item_t  out_data
);
  import lbat_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W:0] LAST = (IDX_W + 1)'(ENTRIES);
  localparam logic [IDX_W:0] ONE  = (IDX_W + 1)'(1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_RANK   = 5'b01000,
    ST_FIN    = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    RK_NONE, RK_INC_ALL, RK_DEC_GT, RK_INC_LT
  } rank_op_t;

  logic [KEY_W-1:0]  key_mem  [ENTRIES];
  logic [SIZE_W-1:0] size_mem [ENTRIES];
  logic [IDX_W-1:0]  rank_mem [ENTRIES];

  state_t            state_r, state_nxt;
  cmd_t              cmd_r;
  logic [ENTRIES-1:0] vld_r;
  logic [IDX_W:0]    count_r;
  logic [USED_W-1:0] total_r;
  logic [IDX_W:0]    cnt_r;
  logic              pv_r;
  logic [IDX_W-1:0]  pidx_r;
  logic [IDX_W-1:0]  rd_addr;
  logic [KEY_W-1:0]  key_q;
  logic [SIZE_W-1:0] size_q;
  logic [IDX_W-1:0]  rank_q;

  logic              hit_r, free_r, ev_r;
  logic [IDX_W-1:0]  hit_slot_r, free_slot_r, ev_slot_r;
  logic [IDX_W-1:0]  hit_rank_r, ev_rank_r;
  logic [SIZE_W-1:0] hit_size_r, ev_size_r;
  logic [KEY_W-1:0]  ev_key_r;

  rank_op_t          op_r;
  logic [IDX_W-1:0]  pivot_r;
  logic [IDX_W-1:0]  tgt_r;
  logic              wr_key_r, wr_size_r, wr_rank0_r;
  logic [1:0]        status_r;
  logic              evv_r;
  logic [KEY_W-1:0]  evk_r;

  logic              out_valid_r;
  out_item_t         out_r;

  logic              sweep_done;
  logic              fin_fire;
  logic              rk_we;
  logic [IDX_W-1:0]  rk_wa;
  logic [IDX_W-1:0]  rk_wd;
  logic              rank_hit;

  assign rd_addr    = cnt_r[IDX_W-1:0];
  assign sweep_done = (cnt_r == LAST) && !pv_r;
  assign fin_fire   = (state_r == ST_FIN) && (!out_valid_r || !out_stall);
  assign q_pop      = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (q_valid) state_nxt = ST_SCAN;
      ST_SCAN:   if (sweep_done) state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = ST_RANK;
      ST_RANK:   if (sweep_done) state_nxt = ST_FIN;
      ST_FIN:    if (fin_fire) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Rank pass decides per valid entry whether its rank moves.
  always_comb begin
    case (op_r)
      RK_INC_ALL: rank_hit = 1'b1;
      RK_DEC_GT:  rank_hit = (rank_q > pivot_r);
      RK_INC_LT:  rank_hit = (rank_q < pivot_r);
      default:    rank_hit = 1'b0;
    endcase
    rk_we = 1'b0;
    rk_wa = pidx_r;
    rk_wd = (op_r == RK_DEC_GT) ? (rank_q - IDX_W'(1)) : (rank_q + IDX_W'(1));
    if (state_r == ST_RANK && pv_r && vld_r[pidx_r] && rank_hit) begin
      rk_we = 1'b1;
    end else if (state_r == ST_FIN && wr_rank0_r) begin
      rk_we = 1'b1;
      rk_wa = tgt_r;
      rk_wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    key_q  <= key_mem[rd_addr];
    size_q <= size_mem[rd_addr];
    rank_q <= rank_mem[rd_addr];
    if (rk_we) rank_mem[rk_wa] <= rk_wd;
    if (state_r == ST_FIN && wr_key_r) key_mem[tgt_r] <= cmd_r.key;
    if (state_r == ST_FIN && wr_size_r) size_mem[tgt_r] <= cmd_r.size;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= '0;
      count_r     <= '0;
      total_r     <= '0;
      cnt_r       <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fin_fire) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;

      if (state_r == ST_SCAN || state_r == ST_RANK) begin
        if (cnt_r != LAST) begin
          pv_r   <= 1'b1;
          pidx_r <= cnt_r[IDX_W-1:0];
          cnt_r  <= cnt_r + ONE;
        end else begin
          pv_r <= 1'b0;
        end
      end

      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            cmd_r  <= q_cmd;
            cnt_r  <= '0;
            hit_r  <= 1'b0;
            free_r <= 1'b0;
            ev_r   <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (pv_r) begin
            if (vld_r[pidx_r]) begin
              if (!hit_r && key_q == cmd_r.key) begin
                hit_r      <= 1'b1;
                hit_slot_r <= pidx_r;
                hit_rank_r <= rank_q;
                hit_size_r <= size_q;
              end
              if (!ev_r && {1'b0, rank_q} == count_r - ONE) begin
                ev_r      <= 1'b1;
                ev_slot_r <= pidx_r;
                ev_rank_r <= rank_q;
                ev_size_r <= size_q;
                ev_key_r  <= key_q;
              end
            end else if (!free_r) begin
              free_r      <= 1'b1;
              free_slot_r <= pidx_r;
            end
          end
        end
        ST_DECIDE: begin
          cnt_r      <= '0;
          op_r       <= RK_NONE;
          wr_key_r   <= 1'b0;
          wr_size_r  <= 1'b0;
          wr_rank0_r <= 1'b0;
          evv_r      <= 1'b0;
          evk_r      <= '0;
          status_r   <= STAT_DONE;
          unique case (cmd_r.mode)
            MODE_ALLOC: begin
              if (cmd_r.over) begin
                status_r <= STAT_OVER;
              end else if (hit_r) begin
                total_r   <= total_r - USED_W'(hit_size_r) + USED_W'(cmd_r.size);
                tgt_r     <= hit_slot_r;
                wr_size_r <= 1'b1;
              end else if (!free_r) begin
                status_r <= STAT_FULL;
              end else begin
                // The new entry is marked valid now; the sweep bumps it and
                // the final write puts it at rank zero.
                vld_r[free_slot_r] <= 1'b1;
                count_r    <= count_r + ONE;
                total_r    <= total_r + USED_W'(cmd_r.size);
                tgt_r      <= free_slot_r;
                wr_key_r   <= 1'b1;
                wr_size_r  <= 1'b1;
                wr_rank0_r <= 1'b1;
                op_r       <= RK_INC_ALL;
              end
            end
            MODE_FREE: begin
              if (hit_r) begin
                vld_r[hit_slot_r] <= 1'b0;
                count_r <= count_r - ONE;
                total_r <= total_r - USED_W'(hit_size_r);
                op_r    <= RK_DEC_GT;
                pivot_r <= hit_rank_r;
              end else begin
                status_r <= STAT_MISS;
              end
            end
            MODE_TOUCH: begin
              if (hit_r) begin
                op_r       <= RK_INC_LT;
                pivot_r    <= hit_rank_r;
                tgt_r      <= hit_slot_r;
                wr_rank0_r <= 1'b1;
              end else begin
                status_r <= STAT_MISS;
              end
            end
            MODE_EVICT: begin
              if (ev_r && count_r != '0) begin
                evv_r   <= 1'b1;
                evk_r   <= ev_key_r;
                vld_r[ev_slot_r] <= 1'b0;
                count_r <= count_r - ONE;
                total_r <= total_r - USED_W'(ev_size_r);
                op_r    <= RK_DEC_GT;
                pivot_r <= ev_rank_r;
              end else begin
                status_r <= STAT_MISS;
              end
            end
            default: status_r <= STAT_MISS;
          endcase
        end
        ST_RANK: begin
        end
        ST_FIN: begin
          if (fin_fire) begin
            out_r.status             <= status_r;
            out_r.evicted_valid      <= evv_r;
            out_r.evicted_index      <= evk_r[HALF_W-1:0];
            out_r.evicted_generation <= evk_r[KEY_W-1:HALF_W];
            out_r.used_bytes         <= total_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/lru_budget_allocation_tracker.sv -----
// Top level of the LRU allocation tracker: budget register, front queue and back end.
// Each request passes a scan sweep, a decide step, a rank sweep and a final write-out step.
// The back end takes the next request only after the last one's result is registered.
// A two-deep request queue and an output register let both sides stall independently.
// Reset (synchronous, rst_n low) empties the table, the total, the queue and the budget.
`timescale 1ns / 1ps
module lru_budget_allocation_tracker #(
  parameter int ENTRIES   = 64,
  parameter int SIZE_BITS = 48
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  lbat_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lbat_pkg::out_item_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lbat_pkg::SIZE_W-1:0] cfg_data
);
  import lbat_pkg::*;

  logic [SIZE_W-1:0] budget_r;
  logic              q_valid;
  cmd_t              q_cmd;
  logic              q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      budget_r <= cfg_data;
    end
  end

  lbat_front #(.SIZE_BITS(SIZE_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .budget   (budget_r),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  lbat_back #(.ENTRIES(ENTRIES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the LRU allocation tracker with a size budget.
`timescale 1ns / 1ps
module tb;
  import lbat_pkg::*;

  localparam int NSLOT = 64;
  localparam int WATCH_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;
  localparam int IN_W = $bits(in_item_t);

  class tracker_scoreboard;
    logic [KEY_W-1:0]  slot_key [NSLOT];
    logic [SIZE_W-1:0] slot_size [NSLOT];
    bit                slot_live [NSLOT];
    int                slot_rank [NSLOT];
    int                live_count;
    logic [USED_W-1:0] used_total;
    logic [SIZE_W-1:0] budget;
    out_item_t         pending [$];
    int                errors;

    function new();
      for (int i = 0; i < NSLOT; i++) slot_live[i] = 0;
      live_count = 0;
      used_total = '0;
      budget = '0;
      errors = 0;
    endfunction

    function int find_key(logic [KEY_W-1:0] k);
      for (int i = 0; i < NSLOT; i++)
        if (slot_live[i] && slot_key[i] == k) return i;
      return -1;
    endfunction

    function void drop_slot(int s);
      used_total = used_total - USED_W'(slot_size[s]);
      slot_live[s] = 0;
      for (int i = 0; i < NSLOT; i++)
        if (slot_live[i] && slot_rank[i] > slot_rank[s]) slot_rank[i]--;
      live_count--;
    endfunction

    function void note_request(in_item_t r);
      out_item_t o;
      logic [KEY_W-1:0] k;
      int s;
      o = '0;
      o.status = STAT_DONE;
      k = {r.handle_generation, r.handle_index};
      case (r.mode)
        MODE_ALLOC: begin
          if (r.size_bytes > budget) o.status = STAT_OVER;
          else begin
            s = find_key(k);
            if (s >= 0) begin
              used_total = used_total - USED_W'(slot_size[s]) + USED_W'(r.size_bytes);
              slot_size[s] = r.size_bytes;
            end else begin
              s = -1;
              for (int i = NSLOT - 1; i >= 0; i--) if (!slot_live[i]) s = i;
              if (s < 0) o.status = STAT_FULL;
              else begin
                for (int i = 0; i < NSLOT; i++) if (slot_live[i]) slot_rank[i]++;
                slot_live[s] = 1;
                slot_key[s] = k;
                slot_size[s] = r.size_bytes;
                slot_rank[s] = 0;
                live_count++;
                used_total = used_total + USED_W'(r.size_bytes);
              end
            end
          end
        end
        MODE_FREE: begin
          s = find_key(k);
          if (s < 0) o.status = STAT_MISS;
          else drop_slot(s);
        end
        MODE_TOUCH: begin
          s = find_key(k);
          if (s < 0) o.status = STAT_MISS;
          else begin
            for (int i = 0; i < NSLOT; i++)
              if (slot_live[i] && slot_rank[i] < slot_rank[s]) slot_rank[i]++;
            slot_rank[s] = 0;
          end
        end
        default: begin
          s = -1;
          for (int i = 0; i < NSLOT; i++)
            if (s < 0 && slot_live[i] && slot_rank[i] == live_count - 1) s = i;
          if (s < 0) o.status = STAT_MISS;
          else begin
            o.evicted_valid = 1'b1;
            {o.evicted_generation, o.evicted_index} = slot_key[s];
            drop_slot(s);
          end
        end
      endcase
      o.used_bytes = used_total;
      pending.push_back(o);
    endfunction

    function void check_result(out_item_t got);
      out_item_t w;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.status !== w.status) begin
        $error("status exp %0d got %0d", w.status, got.status); errors++;
      end
      if (got.evicted_valid !== w.evicted_valid) begin
        $error("evicted_valid exp %0d got %0d", w.evicted_valid, got.evicted_valid);
        errors++;
      end
      if (got.evicted_index !== w.evicted_index) begin
        $error("evicted_index exp %h got %h", w.evicted_index, got.evicted_index);
        errors++;
      end
      if (got.evicted_generation !== w.evicted_generation) begin
        $error("evicted_generation exp %h got %h", w.evicted_generation,
               got.evicted_generation);
        errors++;
      end
      if (got.used_bytes !== w.used_bytes) begin
        $error("used_bytes exp %h got %h", w.used_bytes, got.used_bytes); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0, cfg_valid = 0, cfg_ready;
  in_item_t in_data = '0;
  out_item_t out_data;
  logic [SIZE_W-1:0] cfg_data = '0;

  tracker_scoreboard sb = new();
  int send_idle = 0, recv_idle = 0, quiet = 0;
  logic [HALF_W-1:0] pool_idx [16];
  logic [HALF_W-1:0] pool_gen [16];

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  lru_budget_allocation_tracker u_top (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_valid, .cfg_ready, .cfg_data
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCH_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The receiver stalls at random on every falling edge.
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle);

  // Valid stays up between back-to-back requests; it drops only while the sender idles.
  task automatic send_request(in_item_t r);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_budget(logic [SIZE_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.budget = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t make_op(logic [1:0] m, int p, logic [SIZE_W-1:0] sz);
    in_item_t r;
    r.mode = m;
    r.handle_index = pool_idx[p];
    r.handle_generation = pool_gen[p];
    r.size_bytes = sz;
    return r;
  endfunction

  function automatic logic [SIZE_W-1:0] rand_size();
    logic [SIZE_W-1:0] v;
    v = SIZE_W'({$urandom, $urandom});
    case ($urandom_range(3))
      0: return v;
      1: return v & 48'hFFFF;
      2: return '1;
      default: return v >> $urandom_range(47);
    endcase
  endfunction

  task automatic random_phase(int n);
    in_item_t r;
    int c;
    for (int k = 0; k < n; k++) begin
      c = $urandom_range(99);
      if (c < 10) begin
        r = IN_W'({$urandom, $urandom, $urandom, $urandom});
      end else if (c < 50) r = make_op(MODE_ALLOC, $urandom_range(15), rand_size());
      else if (c < 65) r = make_op(MODE_FREE, $urandom_range(15), rand_size());
      else if (c < 80) r = make_op(MODE_TOUCH, $urandom_range(15), rand_size());
      else r = make_op(MODE_EVICT, $urandom_range(15), rand_size());
      send_request(r);
    end
  endtask

  initial begin
    in_item_t r;
    for (int i = 0; i < 16; i++) begin
      pool_idx[i] = (i == 0) ? '0 : (i == 1) ? '1 : $urandom;
      pool_gen[i] = (i == 0) ? '1 : (i == 1) ? '0 : $urandom;
    end
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // With the reset budget of zero, only zero-sized allocations pass the budget check.
    send_request(make_op(MODE_EVICT, 0, '0));
    send_request(make_op(MODE_ALLOC, 0, 48'd1));
    send_request(make_op(MODE_ALLOC, 0, '0));
    wait_idle();
    write_budget('1);
    send_request(make_op(MODE_ALLOC, 1, '1));
    send_request(make_op(MODE_ALLOC, 2, 48'd100));
    send_request(make_op(MODE_ALLOC, 1, 48'd5));
    send_request(make_op(MODE_TOUCH, 0, '0));
    send_request(make_op(MODE_TOUCH, 3, '0));
    send_request(make_op(MODE_FREE, 3, '0));
    send_request(make_op(MODE_FREE, 2, '0));
    send_request(make_op(MODE_EVICT, 0, '0));
    send_request(make_op(MODE_EVICT, 0, '0));
    send_request(make_op(MODE_EVICT, 0, '0));
    // Fill the table to capacity, then ask for one more new key.
    for (int i = 0; i < NSLOT; i++) begin
      r = make_op(MODE_ALLOC, 0, 48'(i));
      r.handle_index = i;
      send_request(r);
    end
    r.handle_index = 32'hDEAD_0000;
    send_request(r);
    for (int i = 0; i < NSLOT; i++) send_request(make_op(MODE_EVICT, 0, '0));
    wait_idle();

    send_idle = 29; recv_idle = 79;
    write_budget(48'h8000);
    random_phase(450);
    wait_idle();
    send_idle = 79; recv_idle = 29;
    write_budget(SIZE_W'({$urandom, $urandom}));
    random_phase(450);
    wait_idle();
    send_idle = 0; recv_idle = 0;
    write_budget('1);
    random_phase(700);
    wait_idle();

    if (sb.errors == 0 && sb.pending.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
